// ===== rtl/evdm_pkg.sv =====
package evdm_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int OP_W       = 2;
  localparam int COORD_W    = 9;
  localparam int SIZE_W     = 10;
  localparam int MARK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int EPOCH_W    = 4;
  localparam int STEP_W     = 4;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 10'd346;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 10'd260;
  localparam logic [MARK_W-1:0] MARK_VALUE_RST   = 8'd100;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MARK_VALUE   = 2'd2
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_load;
    logic evt_rd;
    logic rd_issue;
    logic out_load;
    logic epoch_inc;
    logic clr_start;
    logic clr_step;
  } evdm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic step_last;
    logic epoch_full;
    logic clr_done;
  } evdm_sts_t;

endpackage

// ===== rtl/evdm_ram.sv =====
module evdm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/evdm_ctrl.sv =====
module evdm_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [evdm_pkg::OP_W-1:0]       in_op,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  evdm_pkg::evdm_sts_t             sts,
  output evdm_pkg::evdm_cmd_t             cmd
);

  typedef enum logic [4:0] {
    S_CLR     = 5'b00001,
    S_IDLE    = 5'b00010,
    S_EVT     = 5'b00100,
    S_RD_REQ  = 5'b01000,
    S_RD_DATA = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          case (evdm_pkg::op_t'(in_op))
            evdm_pkg::OP_EVENT: state_nxt = S_EVT;
            evdm_pkg::OP_READ:  state_nxt = S_RD_REQ;
            evdm_pkg::OP_CLEAR: begin
              // Tags run out after the last epoch; only then is the map swept.
              if (sts.epoch_full) begin
                cmd.clr_start = 1'b1;
                state_nxt     = S_CLR;
              end else begin
                cmd.epoch_inc = 1'b1;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EVT: begin
        cmd.evt_rd = 1'b1;
        if (sts.step_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_REQ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/evdm_datapath.sv =====
module evdm_datapath #(
  parameter int MAX_WIDTH  = evdm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = evdm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [evdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [evdm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [evdm_pkg::COORD_W-1:0]       in_col,
  input  logic [evdm_pkg::COORD_W-1:0]       in_row,
  input  evdm_pkg::evdm_cmd_t                cmd,
  output evdm_pkg::evdm_sts_t                sts,
  output logic [evdm_pkg::MARK_W-1:0]        out_cell_value
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int AW     = CW + RW;
  localparam int DEPTH  = 2 ** AW;
  localparam int WORD_W = evdm_pkg::EPOCH_W + evdm_pkg::MARK_W;
  localparam int CE_W   = (CW + 1 > evdm_pkg::SIZE_W) ? CW + 1 : evdm_pkg::SIZE_W;
  localparam int RE_W   = (RW + 1 > evdm_pkg::SIZE_W) ? RW + 1 : evdm_pkg::SIZE_W;
  localparam logic [evdm_pkg::STEP_W-1:0] STEP_CENTRE = 4'd4;
  localparam logic [evdm_pkg::STEP_W-1:0] STEP_LAST   = 4'd8;

  // Column offset within the 3x3 block for each step.
  function automatic logic [1:0] step_dc(input logic [evdm_pkg::STEP_W-1:0] s);
    case (s) inside
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  // Row offset within the 3x3 block for each step.
  function automatic logic [1:0] step_dr(input logic [evdm_pkg::STEP_W-1:0] s);
    case (s) inside
      4'd0, 4'd1, 4'd2: return 2'd0;
      4'd3, 4'd4, 4'd5: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  logic [evdm_pkg::SIZE_W-1:0]  fw_r, fw_nxt, fh_r, fh_nxt;
  logic [evdm_pkg::MARK_W-1:0]  mark_r, mark_nxt;
  logic [evdm_pkg::COORD_W-1:0] col_r, row_r;
  logic [evdm_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [evdm_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [AW-1:0]                clr_addr_r, clr_addr_nxt;
  logic                         wb_vld_r;
  logic [AW-1:0]                wb_addr_r;
  logic                         wb_in_r, wb_centre_r, rd_in_r;
  logic [evdm_pkg::MARK_W-1:0]  out_cell_r;

  logic [CE_W-1:0]             evt_c, rd_c;
  logic [RE_W-1:0]             evt_r, rd_r;
  logic                        evt_in, rd_in;
  logic [AW-1:0]               evt_addr, rd_addr;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [WORD_W-1:0]           ram_wdata, ram_rdata;
  logic [evdm_pkg::MARK_W-1:0] cell_val, cell_new;

  always_comb begin
    fw_nxt   = fw_r;
    fh_nxt   = fh_r;
    mark_nxt = mark_r;
    if (cfg_valid) begin
      unique case (evdm_pkg::cfg_idx_t'(cfg_index))
        evdm_pkg::CFG_FRAME_WIDTH:  fw_nxt   = cfg_data;
        evdm_pkg::CFG_FRAME_HEIGHT: fh_nxt   = cfg_data;
        evdm_pkg::CFG_MARK_VALUE:   mark_nxt = cfg_data[evdm_pkg::MARK_W-1:0];
        default: ;
      endcase
    end
  end

  // Event cell coordinates and frame test; the map is addressed as {row, col}.
  assign evt_c  = CE_W'(col_r) + CE_W'(step_dc(step_r));
  assign evt_r  = RE_W'(row_r) + RE_W'(step_dr(step_r));
  assign evt_in = (evt_c < CE_W'(MAX_WIDTH)) && (evt_c < CE_W'(fw_r)) &&
                  (evt_r < RE_W'(MAX_HEIGHT)) && (evt_r < RE_W'(fh_r));
  assign evt_addr = {evt_r[RW-1:0], evt_c[CW-1:0]};

  assign rd_c  = CE_W'(col_r);
  assign rd_r  = RE_W'(row_r);
  assign rd_in = (rd_c < CE_W'(MAX_WIDTH)) && (rd_c < CE_W'(fw_r)) &&
                 (rd_r < RE_W'(MAX_HEIGHT)) && (rd_r < RE_W'(fh_r));
  assign rd_addr = {rd_r[RW-1:0], rd_c[CW-1:0]};

  // A cell tagged with an older epoch was cleared since it was written.
  assign cell_val = (ram_rdata[WORD_W-1 -: evdm_pkg::EPOCH_W] == epoch_r) ?
                    ram_rdata[evdm_pkg::MARK_W-1:0] : '0;
  assign cell_new = wb_centre_r ? mark_r :
                    (cell_val != '0) ? cell_val - evdm_pkg::MARK_W'(1) : '0;

  assign ram_re    = cmd.evt_rd || cmd.rd_issue;
  assign ram_raddr = cmd.evt_rd ? evt_addr : rd_addr;
  assign ram_we    = cmd.clr_step || (wb_vld_r && wb_in_r);
  assign ram_waddr = cmd.clr_step ? clr_addr_r : wb_addr_r;
  assign ram_wdata = cmd.clr_step ? {epoch_r, evdm_pkg::MARK_W'(0)} : {epoch_r, cell_new};

  evdm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    step_nxt = step_r;
    if (cmd.item_load) begin
      step_nxt = '0;
    end else if (cmd.evt_rd) begin
      step_nxt = step_r + evdm_pkg::STEP_W'(1);
    end
    epoch_nxt = epoch_r;
    if (cmd.clr_start) begin
      epoch_nxt = '0;
    end else if (cmd.epoch_inc) begin
      epoch_nxt = epoch_r + evdm_pkg::EPOCH_W'(1);
    end
    clr_addr_nxt = clr_addr_r;
    if (cmd.clr_start) begin
      clr_addr_nxt = '0;
    end else if (cmd.clr_step) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= evdm_pkg::FRAME_WIDTH_RST;
      fh_r       <= evdm_pkg::FRAME_HEIGHT_RST;
      mark_r     <= evdm_pkg::MARK_VALUE_RST;
      step_r     <= '0;
      epoch_r    <= '0;
      clr_addr_r <= '0;
      wb_vld_r   <= 1'b0;
    end else begin
      fw_r       <= fw_nxt;
      fh_r       <= fh_nxt;
      mark_r     <= mark_nxt;
      step_r     <= step_nxt;
      epoch_r    <= epoch_nxt;
      clr_addr_r <= clr_addr_nxt;
      wb_vld_r   <= cmd.evt_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      col_r <= in_col;
      row_r <= in_row;
    end
    if (cmd.evt_rd) begin
      wb_addr_r   <= evt_addr;
      wb_in_r     <= evt_in;
      wb_centre_r <= (step_r == STEP_CENTRE);
    end
    if (cmd.rd_issue) begin
      rd_in_r <= rd_in;
    end
    if (cmd.out_load) begin
      out_cell_r <= rd_in_r ? cell_val : '0;
    end
  end

  assign sts.step_last  = (step_r == STEP_LAST);
  assign sts.epoch_full = &epoch_r;
  assign sts.clr_done   = &clr_addr_r;

  assign out_cell_value = out_cell_r;

endmodule

// ===== rtl/event_neighbourhood_decay_map.sv =====
// Activity map for an event sensor, one 8-bit cell per pixel.
// Input channel (in_valid / in_stall) carries op, col and row. An event item
// stamps mark_value into cell (col+1,row+1) and decrements the other eight
// cells of the 3x3 block, saturating at zero; cells outside the configured
// frame are left alone. A read item returns one cell on the output channel
// (out_valid / out_stall); a clear item zeroes the whole map.
// An event occupies the block while it makes nine reads of the frame
// memory, each written back in the next cycle on the second port. A read
// passes through a request state and a data state; its result is registered
// once the output register is free. A clear only advances the 4-bit epoch
// tag that cells carry; every 16th clear exhausts the tags and sweeps all
// 2^(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT)) cells (262144 at 512x512).
// Reset sets the registers to their defaults and runs the same sweep; in_stall
// is high throughout. Configuration writes (cfg_valid, always ready) are taken
// at any time and must arrive only while the block is idle.
// The result sits in an output register; while out_stall is high, event and
// clear items are still taken, and a taken read waits until it drains.
module event_neighbourhood_decay_map #(
  parameter int MAX_WIDTH  = evdm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = evdm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [evdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evdm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [evdm_pkg::OP_W-1:0]       in_op,
  input  logic [evdm_pkg::COORD_W-1:0]    in_col,
  input  logic [evdm_pkg::COORD_W-1:0]    in_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [evdm_pkg::MARK_W-1:0]     out_cell_value
);

  evdm_pkg::evdm_cmd_t cmd;
  evdm_pkg::evdm_sts_t sts;

  assign cfg_ready = 1'b1;

  evdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  evdm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_col         (in_col),
    .in_row         (in_row),
    .cmd            (cmd),
    .sts            (sts),
    .out_cell_value (out_cell_value)
  );

endmodule

// ===== rtl/evdm_checker.sv =====
module evdm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [evdm_pkg::OP_W-1:0]       in_op,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [evdm_pkg::MARK_W-1:0]     out_cell_value
);

  // A result held by the receiver keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_value))
    else $error("stalled result changed or vanished");

  // Reset empties the output register and holds off the input channel.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

  // An event keeps the block busy while its block of cells is updated.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == evdm_pkg::OP_EVENT) |=> in_stall ##1 in_stall)
    else $error("item taken during event update");

  // A read transfer is followed by a busy phase and then a valid result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == evdm_pkg::OP_READ) && !out_valid
    |=> in_stall ##1 in_stall ##1 out_valid)
    else $error("read result missing");

endmodule

bind event_neighbourhood_decay_map evdm_checker u_evdm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_op          (in_op),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_cell_value (out_cell_value)
);
